[hw/rtl/scg_pkg.sv]
// Shared constants for the selectable CRC generator.
// No dependencies; imported by scg_poly_sel, scg_byte_step and the top level.
package scg_pkg;

	localparam int BYTE_W = 8;
	localparam int CRC_W  = 32;
	localparam int DEG_W  = 6;

	// Degree register reset value
	localparam logic [DEG_W-1:0] DEG_RESET = 6'd3;

	// Degrees with fixed generators
	localparam logic [DEG_W-1:0] DEG_CRC3  = 6'd3;
	localparam logic [DEG_W-1:0] DEG_CRC8  = 6'd8;
	localparam logic [DEG_W-1:0] DEG_CRC10 = 6'd10;
	localparam logic [DEG_W-1:0] DEG_CRC16 = 6'd16;
	localparam logic [DEG_W-1:0] DEG_CRC32 = 6'd32;

	// Generators without the x^d term
	localparam logic [63:0] GEN_CRC3  = 64'h3;
	localparam logic [63:0] GEN_CRC8  = 64'h07;
	localparam logic [63:0] GEN_CRC10 = 64'h235;
	localparam logic [63:0] GEN_CRC16 = 64'h1021;
	localparam logic [63:0] GEN_CRC32 = 64'h04C1_1DB7;
	// x^d + x + 1 for all other degrees
	localparam logic [63:0] GEN_TRINOMIAL = 64'h3;

endpackage

[hw/rtl/scg_poly_sel.sv]
// Degree register and polynomial decode for the selectable CRC generator.
// Depends on scg_pkg. Produces width mask, generator and msb select.
module scg_poly_sel import scg_pkg::*; #(
	parameter int MAX_DEGREE = 32
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  cfg_wr,
	input  logic [DEG_W-1:0]      cfg_degree,
	output logic [MAX_DEGREE-1:0] mask_q,
	output logic [MAX_DEGREE-1:0] gen_q,
	output logic [MAX_DEGREE-1:0] top_sel_q
);

	logic [DEG_W-1:0]      eff_deg;
	logic [63:0]           gen_full;
	logic [MAX_DEGREE-1:0] mask_d;
	logic [MAX_DEGREE-1:0] gen_d;
	logic [MAX_DEGREE-1:0] top_sel_d;

	// zero reads as one, above MAX_DEGREE saturates
	always_comb begin
		if (cfg_degree == '0) begin
			eff_deg = DEG_W'(1);
		end else if (int'(cfg_degree) > MAX_DEGREE) begin
			eff_deg = DEG_W'(MAX_DEGREE);
		end else begin
			eff_deg = cfg_degree;
		end
	end

	always_comb begin
		for (int i = 0; i < MAX_DEGREE; i++) begin
			mask_d[i]    = (i < int'(eff_deg));
			top_sel_d[i] = (i == int'(eff_deg) - 1);
		end
	end

	always_comb begin
		case (eff_deg)
			DEG_CRC3:  gen_full = GEN_CRC3;
			DEG_CRC8:  gen_full = GEN_CRC8;
			DEG_CRC10: gen_full = GEN_CRC10;
			DEG_CRC16: gen_full = GEN_CRC16;
			DEG_CRC32: gen_full = GEN_CRC32;
			default:   gen_full = GEN_TRINOMIAL;
		endcase
		gen_d = MAX_DEGREE'(gen_full) & mask_d;
	end

	// reset state decodes degree 3: x^3+x+1
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mask_q    <= MAX_DEGREE'(7);
			gen_q     <= MAX_DEGREE'(GEN_CRC3);
			top_sel_q <= MAX_DEGREE'(4);
		end else if (cfg_wr) begin
			mask_q    <= mask_d;
			gen_q     <= gen_d;
			top_sel_q <= top_sel_d;
		end
	end

	a_top_onehot: assert property (@(posedge clk) disable iff (!arst_n)
		$onehot(top_sel_q))
		else $error("msb select not one-hot");
	a_top_in_mask: assert property (@(posedge clk) disable iff (!arst_n)
		(top_sel_q & mask_q) == top_sel_q && (mask_q & ~(top_sel_q - 1'b1)) == top_sel_q)
		else $error("msb select is not the top bit of the mask");
	a_gen_in_mask: assert property (@(posedge clk) disable iff (!arst_n)
		(gen_q & ~mask_q) == '0 && gen_q[0])
		else $error("generator outside width or missing constant term");

endmodule

[hw/rtl/scg_byte_step.sv]
// One byte of MSB-first CRC division, eight shift/XOR steps unrolled.
// Depends on scg_pkg. Pure combinational logic.
module scg_byte_step import scg_pkg::*; #(
	parameter int MAX_DEGREE = 32
) (
	input  logic [MAX_DEGREE-1:0] rem_in,
	input  logic [BYTE_W-1:0]     data,
	input  logic [MAX_DEGREE-1:0] mask,
	input  logic [MAX_DEGREE-1:0] gen,
	input  logic [MAX_DEGREE-1:0] top_sel,
	output logic [MAX_DEGREE-1:0] rem_out
);

	logic [MAX_DEGREE-1:0] rem;
	logic                  fb;

	always_comb begin
		rem = rem_in & mask;
		fb  = 1'b0;
		for (int b = BYTE_W - 1; b >= 0; b--) begin
			fb  = (|(rem & top_sel)) ^ data[b];
			rem = (rem << 1) & mask;
			if (fb) begin
				rem = rem ^ gen;
			end
		end
		rem_out = rem;
	end

endmodule

[hw/rtl/selectable_crc_generator.sv]
// Selectable CRC generator, top level.
// Depends on scg_pkg, scg_poly_sel and scg_byte_step.
//
// Usage:
//   Input channel (in_valid / in_stall): one message byte per request,
//   data_byte fed MSB first, last_byte marks the end of the message.
//   Output channel (out_valid / out_stall): one request per message,
//   crc_remainder holding the remainder, low d bits valid, rest zero.
//   Config channel (cfg_valid / cfg_ready): poly_degree sets d; write only
//   while no message is in flight. cfg_ready is always high.
//   Degrees 3, 8, 10, 16, 32 use fixed generators, others x^d+x+1;
//   0 acts as 1, values above MAX_DEGREE saturate.
// Timing:
//   One byte per cycle sustained while no final byte is held (see Stall).
//   A byte is registered in the input stage, then folded into the running
//   remainder by the unrolled 8-step shift/XOR network as it leaves that
//   stage; for a final byte the result register loads then and drives the output.
// Stall:
//   Only a final byte waits on the output. While the result register is
//   full and stalled, a held last byte backs up and in_stall goes high;
//   non-final bytes keep flowing.
// Reset:
//   Degree returns to 3, running remainder clears, both channels empty.
module selectable_crc_generator import scg_pkg::*; #(
	parameter int MAX_DEGREE = 32
) (
	input  logic               clk,
	input  logic               arst_n,
	// configuration
	input  logic               cfg_valid,
	output logic               cfg_ready,
	input  logic [DEG_W-1:0]   poly_degree,
	// message bytes
	input  logic               in_valid,
	output logic               in_stall,
	input  logic [BYTE_W-1:0]  data_byte,
	input  logic               last_byte,
	// remainders
	output logic               out_valid,
	input  logic               out_stall,
	output logic [CRC_W-1:0]   crc_remainder
);

	logic [MAX_DEGREE-1:0] mask_q;
	logic [MAX_DEGREE-1:0] gen_q;
	logic [MAX_DEGREE-1:0] top_sel_q;

	// input stage
	logic                  valid_s1;
	logic [BYTE_W-1:0]     data_s1;
	logic                  last_s1;

	// running remainder and result register
	logic [MAX_DEGREE-1:0] rem_q;
	logic [MAX_DEGREE-1:0] rem_next;
	logic                  out_valid_q;
	logic [CRC_W-1:0]      crc_q;

	logic                  out_free;
	logic                  adv_s1;
	logic                  in_take;

	assign cfg_ready = 1'b1;

	scg_poly_sel #(
		.MAX_DEGREE(MAX_DEGREE)
	) u_poly_sel (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg_wr     (cfg_valid && cfg_ready),
		.cfg_degree (poly_degree),
		.mask_q     (mask_q),
		.gen_q      (gen_q),
		.top_sel_q  (top_sel_q)
	);

	scg_byte_step #(
		.MAX_DEGREE(MAX_DEGREE)
	) u_byte_step (
		.rem_in  (rem_q),
		.data    (data_s1),
		.mask    (mask_q),
		.gen     (gen_q),
		.top_sel (top_sel_q),
		.rem_out (rem_next)
	);

	// a non-final byte never needs the output slot
	assign out_free = !out_valid_q || !out_stall;
	assign adv_s1   = valid_s1 && (!last_s1 || out_free);
	assign in_stall = valid_s1 && !adv_s1;
	assign in_take  = in_valid && !in_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_take) begin
			valid_s1 <= 1'b1;
		end else if (adv_s1) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (in_take) begin
			data_s1 <= data_byte;
			last_s1 <= last_byte;
		end
	end

	// remainder clears after a final byte
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rem_q <= '0;
		end else if (adv_s1) begin
			rem_q <= last_s1 ? '0 : rem_next;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (out_free) begin
			out_valid_q <= adv_s1 && last_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (adv_s1 && last_s1) begin
			crc_q <= CRC_W'(rem_next);
		end
	end

	assign out_valid     = out_valid_q;
	assign crc_remainder = crc_q;

	a_stall_needs_item: assert property (@(posedge clk) disable iff (!arst_n)
		in_stall |-> valid_s1 && last_s1 && out_valid_q && out_stall)
		else $error("input stalled without a blocked final byte");
	a_rem_cleared: assert property (@(posedge clk) disable iff (!arst_n)
		adv_s1 && last_s1 |=> rem_q == '0)
		else $error("running remainder not cleared after final byte");
	a_result_from_last: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid_q) |-> $past(adv_s1 && last_s1))
		else $error("result appeared without a final byte");
	a_no_overwrite: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q && out_stall |=> out_valid_q && $stable(crc_q))
		else $error("pending result overwritten");

endmodule

[tb/sv/scg_tb_pkg.sv]
`timescale 1ns / 100ps
// Remainder tracker for the selectable CRC generator testbench.
// Depends on scg_pkg for widths, degree codes and generator constants.
package scg_tb_pkg;
	import scg_pkg::*;

	localparam int MAX_DEG = 32;

	class crc_tracker;
		logic [DEG_W-1:0] degree;
		logic [63:0]      partial_rem;
		logic [CRC_W-1:0] expected_crcs[$];
		int               mismatches;

		function new();
			degree      = DEG_RESET;
			partial_rem = '0;
			mismatches  = 0;
		endfunction

		function void set_degree(logic [DEG_W-1:0] value);
			degree = value;
		endfunction

		// Fold one byte, MSB first, into the running remainder.
		function void absorb_byte(logic [BYTE_W-1:0] data, logic last);
			int unsigned d;
			int          b;
			logic [63:0] mask;
			logic [63:0] gen;
			logic [63:0] rem;
			logic        top;
			d = degree;
			if (d < 1) d = 1;
			if (d > MAX_DEG) d = MAX_DEG;
			mask = (d >= 64) ? '1 : ((64'd1 << d) - 64'd1);
			case (d)
				int'(DEG_CRC3):  gen = GEN_CRC3;
				int'(DEG_CRC8):  gen = GEN_CRC8;
				int'(DEG_CRC10): gen = GEN_CRC10;
				int'(DEG_CRC16): gen = GEN_CRC16;
				int'(DEG_CRC32): gen = GEN_CRC32;
				default:         gen = GEN_TRINOMIAL & mask;
			endcase
			// remainder is cut to the degree in force for this byte
			rem = partial_rem & mask;
			for (b = BYTE_W - 1; b >= 0; b--) begin
				top = rem[d-1] ^ data[b];
				rem = (rem << 1) & mask;
				if (top) rem = rem ^ gen;
			end
			if (last) begin
				expected_crcs.push_back(rem[CRC_W-1:0]);
				partial_rem = '0;
			end else begin
				partial_rem = rem;
			end
		endfunction

		function void check_crc(logic [CRC_W-1:0] got);
			logic [CRC_W-1:0] want;
			if (expected_crcs.size() == 0) begin
				$error("crc_remainder: expected nothing, got %h", got);
				mismatches++;
				return;
			end
			want = expected_crcs.pop_front();
			if (got !== want) begin
				$error("crc_remainder: expected %h, got %h", want, got);
				mismatches++;
			end
		endfunction

		function int pending();
			return expected_crcs.size();
		endfunction
	endclass

endpackage

[tb/sv/tb_selectable_crc_generator.sv]
`timescale 1ns / 100ps
// Top-level testbench for selectable_crc_generator: drives bytes and degree writes.
// Depends on scg_pkg, scg_tb_pkg (crc_tracker) and the generator RTL.
module tb_selectable_crc_generator;
	import scg_pkg::*;
	import scg_tb_pkg::*;

	localparam int HOLD_CYCLES   = 100;  // long receiver hold-off
	localparam int SETTLE_CYCLES = 6;    // pipeline is two deep, leave margin
	localparam int RANDOM_ITEMS  = 1300;
	localparam int PHASES        = 15;

	logic              clk = 1'b0;
	logic              arst_n;
	logic              cfg_valid;
	logic              cfg_ready;
	logic [DEG_W-1:0]  poly_degree;
	logic              in_valid;
	logic              in_stall;
	logic [BYTE_W-1:0] data_byte;
	logic              last_byte;
	logic              out_valid;
	logic              out_stall;
	logic [CRC_W-1:0]  crc_remainder;

	// idle rates in percent, set per phase by the main sequence
	int send_idle_pct = 0;
	int recv_idle_pct = 0;
	// bumped by the sender to ask the receiver for a long hold-off
	int hold_seq = 0;

	crc_tracker crcs = new();

	selectable_crc_generator #(
		.MAX_DEGREE(MAX_DEG)
	) i_dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.cfg_valid    (cfg_valid),
		.cfg_ready    (cfg_ready),
		.poly_degree  (poly_degree),
		.in_valid     (in_valid),
		.in_stall     (in_stall),
		.data_byte    (data_byte),
		.last_byte    (last_byte),
		.out_valid    (out_valid),
		.out_stall    (out_stall),
		.crc_remainder(crc_remainder)
	);

	always #5 clk = ~clk;

	// Monitor: every handshake is sampled at the rising edge. All TB inputs move
	// on the falling edge, so the values seen here are the settled pre-edge ones.
	always @(posedge clk) begin
		if (arst_n) begin
			if (cfg_valid && cfg_ready) crcs.set_degree(poly_degree);
			if (in_valid && !in_stall) crcs.absorb_byte(data_byte, last_byte);
			if (out_valid && !out_stall) crcs.check_crc(crc_remainder);
		end
	end

	// Receiver: random stall, or a counted hold-off when the sender asks for one.
	initial begin
		int hold_seen;
		int hold_left;
		hold_seen = 0;
		hold_left = 0;
		out_stall = 1'b0;
		forever begin
			@(negedge clk);
			if (hold_seq != hold_seen) begin
				hold_seen = hold_seq;
				hold_left = HOLD_CYCLES;
			end
			if (hold_left > 0) begin
				hold_left--;
				out_stall <= 1'b1;
			end else begin
				out_stall <= ($urandom_range(99) < recv_idle_pct);
			end
		end
	end

	// One byte request. Called at a falling edge, returns at a falling edge with
	// in_valid still high, so back-to-back requests need no second assignment.
	task automatic send_byte(input logic [BYTE_W-1:0] data, input logic last);
		while ($urandom_range(99) < send_idle_pct) begin
			in_valid  <= 1'b0;
			data_byte <= BYTE_W'($urandom);
			last_byte <= 1'($urandom);
			@(negedge clk);
		end
		in_valid  <= 1'b1;
		data_byte <= data;
		last_byte <= last;
		do @(posedge clk); while (in_stall);
		@(negedge clk);
	endtask

	// Sender pause: wait for every remainder, then let the pipeline drain,
	// since a non-final byte may still be in flight with nothing expected.
	task automatic wait_idle();
		in_valid <= 1'b0;
		while (crcs.pending() != 0) @(negedge clk);
		repeat (SETTLE_CYCLES) @(negedge clk);
	endtask

	task automatic write_degree(input logic [DEG_W-1:0] value);
		cfg_valid   <= 1'b1;
		poly_degree <= value;
		do @(posedge clk); while (!cfg_ready);
		@(negedge clk);
		cfg_valid <= 1'b0;
	endtask

	// Random messages. Most are proper messages of a few bytes, some long,
	// the rest single bytes with a random last flag. A burst is mostly
	// one-byte messages, to pile remainders up against a stalled output.
	// A phase may end mid-message; the next degree then applies to the rest.
	task automatic run_messages(input int n_items, input bit burst);
		int                i;
		int                msg_left;
		int                pick;
		logic              last;
		logic [BYTE_W-1:0] data;
		msg_left = 0;
		for (i = 0; i < n_items; i++) begin
			if (msg_left == 0) begin
				pick = $urandom_range(99);
				if (burst) msg_left = ($urandom_range(3) == 0) ? 2 : 1;
				else if (pick < 60) msg_left = $urandom_range(8, 1);
				else if (pick < 80) msg_left = $urandom_range(40, 9);
			end
			if (msg_left == 0) begin
				last = 1'($urandom_range(1));
			end else begin
				msg_left--;
				last = (msg_left == 0);
			end
			case ($urandom_range(9))
				0:       data = '0;
				1:       data = '1;
				default: data = BYTE_W'($urandom);
			endcase
			send_byte(data, last);
		end
	endtask

	initial begin
		int               ph;
		logic [DEG_W-1:0] deg;
		arst_n      = 1'b0;
		cfg_valid   = 1'b0;
		poly_degree = DEG_RESET;
		in_valid    = 1'b0;
		data_byte   = '0;
		last_byte   = 1'b0;
		repeat (8) @(negedge clk);
		arst_n <= 1'b1;
		repeat (2) @(negedge clk);

		// Directed: reset degree first, then every fixed generator,
		// the trinomial cases, degree zero and saturation.
		send_byte(8'h00, 1'b1);
		send_byte(8'hFF, 1'b1);
		wait_idle();
		write_degree(DEG_CRC8);
		send_byte(8'hA5, 1'b0);
		send_byte(8'hFF, 1'b1);
		wait_idle();
		write_degree(DEG_CRC10);
		send_byte(8'h01, 1'b1);
		wait_idle();
		write_degree(DEG_CRC16);
		send_byte(8'h31, 1'b0);
		send_byte(8'h32, 1'b0);
		send_byte(8'h33, 1'b1);
		wait_idle();
		write_degree(DEG_CRC32);
		send_byte(8'hFF, 1'b0);
		send_byte(8'h00, 1'b1);
		wait_idle();
		write_degree(6'd1);       // x+1
		send_byte(8'h7F, 1'b1);
		wait_idle();
		write_degree(6'd0);       // acts as degree one
		send_byte(8'h80, 1'b1);
		wait_idle();
		write_degree(6'd63);      // saturates
		send_byte(8'hFF, 1'b1);
		wait_idle();
		write_degree(6'd33);
		send_byte(8'h5A, 1'b1);
		wait_idle();
		// degree switched in the middle of a message
		write_degree(6'd5);
		send_byte(8'hC3, 1'b0);
		wait_idle();
		write_degree(6'd12);
		send_byte(8'h3C, 1'b1);
		wait_idle();
		// two-byte message at degree two: the non-final byte gives no remainder
		write_degree(6'd2);
		send_byte(8'hFF, 1'b0);
		send_byte(8'h00, 1'b1);
		wait_idle();

		for (ph = 0; ph < PHASES; ph++) begin
			wait_idle();
			if (ph < 5) begin
				send_idle_pct = 21;
				recv_idle_pct = 84;
			end else if (ph < 10) begin
				send_idle_pct = 84;
				recv_idle_pct = 21;
			end else begin
				send_idle_pct = 0;
				recv_idle_pct = 0;
			end
			if ($urandom_range(1) == 0) begin
				case ($urandom_range(6))
					0:       deg = DEG_CRC3;
					1:       deg = DEG_CRC8;
					2:       deg = DEG_CRC10;
					3:       deg = DEG_CRC16;
					4:       deg = DEG_CRC32;
					5:       deg = 6'd1;
					default: deg = 6'd63;
				endcase
			end else begin
				deg = DEG_W'($urandom_range(63));
			end
			write_degree(deg);
			if (ph == 1 || ph == 12) begin
				// receiver holds off while the sender keeps offering
				hold_seq <= hold_seq + 1;
				run_messages(RANDOM_ITEMS / PHASES, 1'b1);
			end else begin
				run_messages(RANDOM_ITEMS / PHASES, 1'b0);
			end
		end

		wait_idle();
		if (crcs.mismatches == 0) begin
			$display("ALL CHECKS PASSED");
		end else begin
			$display("CHECKS FAILED");
		end
		$finish;
	end

	// Watchdog, far beyond the slowest correct run.
	initial begin
		#5000000;
		$display("CHECKS FAILED");
		$finish;
	end

endmodule
